// File: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants for the pressure/temperature compensation block: register
// indexes, kind codes, datapath widths and the fixed calibration constants.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DW       = 32;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic signed [DW-1:0] K_B6_OFS   = 32'sd4000;
    localparam logic signed [DW-1:0] K_B4_OFS   = 32'sd32768;
    localparam logic [DW-1:0]        K_B7_SCALE = 32'd50000;
    localparam logic signed [DW-1:0] K_P_C1     = 32'sd3038;
    localparam logic signed [DW-1:0] K_P_C2     = -32'sd7357;
    localparam logic signed [DW-1:0] K_P_C3     = 32'sd3791;

endpackage

// File: rtl/core/bpc_mul.sv
// ----------------------------------------------------------------------------
// bpc_mul
// Shared 32x32 multiplier, low 32 bits of the product, registered output.
// ----------------------------------------------------------------------------
module bpc_mul (
    input  logic                   i_clk,
    input  logic [bpc_pkg::DW-1:0] i_a,
    input  logic [bpc_pkg::DW-1:0] i_b,
    output logic [bpc_pkg::DW-1:0] o_p
);
    import bpc_pkg::*;

    logic [DW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: rtl/core/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [bpc_pkg::DW-1:0] i_num,
    input  logic [bpc_pkg::DW-1:0] i_den,
    output logic                   o_done,
    output logic [bpc_pkg::DW-1:0] o_quot
);
    import bpc_pkg::*;

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            // keep the trial difference as the partial remainder only when the subtract fits
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
            end else begin
                r_rem <= shifted[DW-1:0];
            end
            r_quo <= {r_quo[DW-2:0], ~diff[DW]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/core/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Factory-calibration compensation of raw temperature and pressure readings,
// run as a sequencer over one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_stall    i_kind, i_raw_reading
//  output    o_out_valid / i_out_stall  o_result_kind, o_value, o_div_error
//  config    i_cfg_we                   i_cfg_index, i_cfg_data
//
//  Temperature and pressure both run multiplies on the shared multiplier and a
//  divide on the serial divider; a zero divisor skips the divide and ends early.
//  One transaction at a time; o_in_stall is high while a reading is at work.
//  The output register lets the next reading start while a result waits.
//  Synchronous active-low reset clears control, coefficients and stored B5.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [bpc_pkg::RAW_W-1:0]     i_raw_reading,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic signed [bpc_pkg::DW-1:0] o_value,
    output logic                          o_div_error,
    input  logic                          i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpc_pkg::DW-1:0]        i_cfg_data
);
    import bpc_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_T0   = 5'd1;
    localparam logic [4:0] ST_T1   = 5'd2;
    localparam logic [4:0] ST_T2   = 5'd3;
    localparam logic [4:0] ST_P0   = 5'd4;
    localparam logic [4:0] ST_P1   = 5'd5;
    localparam logic [4:0] ST_P2   = 5'd6;
    localparam logic [4:0] ST_P3   = 5'd7;
    localparam logic [4:0] ST_P4   = 5'd8;
    localparam logic [4:0] ST_P5   = 5'd9;
    localparam logic [4:0] ST_P6   = 5'd10;
    localparam logic [4:0] ST_P7   = 5'd11;
    localparam logic [4:0] ST_P8   = 5'd12;
    localparam logic [4:0] ST_P9   = 5'd13;
    localparam logic [4:0] ST_P10  = 5'd14;
    localparam logic [4:0] ST_P11  = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    logic [4:0]           r_state;
    logic [DW-1:0]        r_c12, r_c34, r_c56, r_cb, r_cm;
    logic [1:0]           r_oss;
    logic signed [DW-1:0] r_b5;
    logic                 r_kind;
    logic [RAW_W-1:0]     r_raw;
    logic signed [DW-1:0] r_t, r_sq, r_b3, r_ps;
    logic [DW-1:0]        r_b4;
    logic                 r_sgn;
    logic signed [DW-1:0] r_res_val;
    logic                 r_res_err;
    logic                 r_ov, r_o_kind, r_o_err;
    logic signed [DW-1:0] r_o_val;

    logic [DW-1:0]        mul_a, mul_b, mul_p;
    logic signed [DW-1:0] p;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_num, div_den, div_q;

    logic signed [DW-1:0] ac1, ac2, ac3, b1, b2, mc, md, b6;
    logic [DW-1:0]        ac4, ac5, ac6, ut, up;
    logic signed [DW-1:0] t_x1, t_den, t_num, t_x2, t_b5;
    logic signed [DW-1:0] p_x3, p_t, p_v, p_s5, p_x3b, p_x2b, p_fin;
    logic [DW-1:0]        p_q8, p_ps;
    logic                 in_acc;

    assign ac1 = DW'(signed'(r_c12[31:16]));
    assign ac2 = DW'(signed'(r_c12[15:0]));
    assign ac3 = DW'(signed'(r_c34[31:16]));
    assign ac4 = DW'(r_c34[15:0]);
    assign ac5 = DW'(r_c56[31:16]);
    assign ac6 = DW'(r_c56[15:0]);
    assign b1  = DW'(signed'(r_cb[31:16]));
    assign b2  = DW'(signed'(r_cb[15:0]));
    assign mc  = DW'(signed'(r_cm[31:16]));
    assign md  = DW'(signed'(r_cm[15:0]));
    assign b6  = r_b5 - K_B6_OFS;
    assign ut  = DW'(r_raw[15:0]);
    assign up  = DW'(r_raw) >> (4'd8 - {2'b00, r_oss});
    assign p   = signed'(mul_p);

    // temperature path
    assign t_x1  = p >>> 15;
    assign t_den = t_x1 + md;
    assign t_num = mc <<< 11;
    assign t_x2  = r_sgn ? -signed'(div_q) : signed'(div_q);
    assign t_b5  = r_t + t_x2;

    // pressure path
    assign p_x3  = r_t + (p >>> 11);
    assign p_t   = ((ac1 <<< 2) + p_x3) <<< r_oss;
    assign p_v   = p_t + 32'sd2;
    assign p_s5  = r_t + (p >>> 16) + 32'sd2;
    assign p_x3b = (p_s5 >>> 2) + K_B4_OFS;
    assign p_ps  = r_sgn ? {div_q[DW-2:0], 1'b0} : div_q;
    assign p_q8  = unsigned'(signed'(p_ps) >>> 8);
    assign p_x2b = p >>> 16;
    assign p_fin = r_ps + ((r_t + p_x2b + K_P_C3) >>> 4);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_T0:  begin mul_a = ut - ac6;           mul_b = ac5;                    end
            ST_P0:  begin mul_a = b6;                 mul_b = b6;                     end
            ST_P1:  begin mul_a = b2;                 mul_b = unsigned'(p >>> 12);    end
            ST_P2:  begin mul_a = ac2;                mul_b = b6;                     end
            ST_P3:  begin mul_a = ac3;                mul_b = b6;                     end
            ST_P4:  begin mul_a = b1;                 mul_b = r_sq;                   end
            ST_P5:  begin mul_a = ac4;                mul_b = p_x3b;                  end
            ST_P6:  begin mul_a = up - r_b3;          mul_b = K_B7_SCALE >> r_oss;    end
            ST_P8:  begin mul_a = p_q8;               mul_b = p_q8;                   end
            ST_P9:  begin mul_a = mul_p;              mul_b = K_P_C1;                 end
            ST_P10: begin mul_a = K_P_C2;             mul_b = r_ps;                   end
            default: begin mul_a = '0;                mul_b = '0;                     end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (r_state == ST_T1 && t_den != '0) begin
            div_start = 1'b1;
            div_num   = t_num[DW-1] ? -t_num : t_num;
            div_den   = t_den[DW-1] ? -t_den : t_den;
        end else if (r_state == ST_P7 && r_b4 != '0) begin
            div_start = 1'b1;
            // skip the doubling when it would overflow; the quotient is doubled afterwards
            div_num   = mul_p[DW-1] ? mul_p : {mul_p[DW-2:0], 1'b0};
            div_den   = r_b4;
        end
    end

    bpc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c12 <= '0;
            r_c34 <= '0;
            r_c56 <= '0;
            r_cb  <= '0;
            r_cm  <= '0;
            r_oss <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AC1_AC2: r_c12 <= i_cfg_data;
                CFG_AC3_AC4: r_c34 <= i_cfg_data;
                CFG_AC5_AC6: r_c56 <= i_cfg_data;
                CFG_B1_B2:   r_cb  <= i_cfg_data;
                CFG_MC_MD:   r_cm  <= i_cfg_data;
                CFG_OSS:     r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_b5    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == ST_OUT && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= (i_kind == KIND_PRESS) ? ST_P0 : ST_T0;
                    end
                end
                ST_T0: r_state <= ST_T1;
                ST_T1: begin
                    if (t_den == '0) begin
                        r_res_val <= '0;
                        r_res_err <= 1'b1;
                        r_state   <= ST_OUT;
                    end else begin
                        r_state <= ST_T2;
                    end
                end
                ST_T2: begin
                    if (div_done) begin
                        r_b5      <= t_b5;
                        r_res_val <= (t_b5 + 32'sd8) >>> 4;
                        r_res_err <= 1'b0;
                        r_state   <= ST_OUT;
                    end
                end
                ST_P0: r_state <= ST_P1;
                ST_P1: r_state <= ST_P2;
                ST_P2: r_state <= ST_P3;
                ST_P3: r_state <= ST_P4;
                ST_P4: r_state <= ST_P5;
                ST_P5: r_state <= ST_P6;
                ST_P6: r_state <= ST_P7;
                ST_P7: begin
                    if (r_b4 == '0) begin
                        r_res_val <= '0;
                        r_res_err <= 1'b1;
                        r_state   <= ST_OUT;
                    end else begin
                        r_state <= ST_P8;
                    end
                end
                ST_P8: begin
                    if (div_done) begin
                        r_state <= ST_P9;
                    end
                end
                ST_P9:  r_state <= ST_P10;
                ST_P10: r_state <= ST_P11;
                ST_P11: begin
                    r_res_val <= p_fin;
                    r_res_err <= 1'b0;
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_ov || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_raw  <= i_raw_reading;
        end
        unique case (r_state)
            ST_T1:  begin
                r_t   <= t_x1;
                r_sgn <= t_num[DW-1] ^ t_den[DW-1];
            end
            ST_P1:  r_sq <= p >>> 12;
            ST_P2:  r_t  <= p >>> 11;
            ST_P3:  r_b3 <= p_v[DW-1] ? ((p_v + 32'sd3) >>> 2) : (p_v >>> 2);
            ST_P4:  r_t  <= p >>> 13;
            ST_P6:  r_b4 <= mul_p >> 15;
            ST_P7:  r_sgn <= mul_p[DW-1];
            ST_P8:  r_ps <= signed'(p_ps);
            ST_P10: r_t  <= p >>> 16;
            default: ;
        endcase
        if (r_state == ST_OUT && (!r_ov || !i_out_stall)) begin
            r_o_kind <= r_kind;
            r_o_val  <= r_res_val;
            r_o_err  <= r_res_err;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_ov;
    assign o_result_kind = r_o_kind;
    assign o_value       = r_o_val;
    assign o_div_error   = r_o_err;

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input not stalled while busy");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == ST_T1 || r_state == ST_P7))
        else $error("divider started outside a divide step");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_T2 || r_state == ST_P8))
        else $error("divider finished with no step waiting");

    a_accept_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_T0 || r_state == ST_P0))
        else $error("accepted transaction did not start");

endmodule
